>>> src/vbpc_pkg.sv
// Shared types, constants and helpers for the ViBe pixel classifier.
// Used by vbpc_engine and vibe_background_pixel_classifier_core.
`timescale 1ns / 1ps
`default_nettype none

package vbpc_pkg;

  localparam int MAX_SAMPLES_DEF  = 32;
  localparam int MAX_WIDTH_DEF    = 512;
  localparam int MAX_HEIGHT_DEF   = 512;
  localparam int NUM_CHANNELS_DEF = 3;

  localparam logic [7:0] MATCH_RADIUS_RST = 8'd20;
  localparam logic [5:0] MIN_MATCHES_RST  = 6'd2;
  localparam logic [5:0] SAMPLE_COUNT_RST = 6'd20;
  localparam logic [9:0] FRAME_WIDTH_RST  = 10'd512;
  localparam logic [9:0] FRAME_HEIGHT_RST = 10'd512;

  // v/20 == (v*205) >> 12 for every 8-bit v
  localparam int QUANT_STEP  = 20;
  localparam int QUANT_RECIP = 205;
  localparam int QUANT_SHIFT = 12;

  typedef enum logic [2:0] {
    CFG_MATCH_RADIUS = 3'd0,
    CFG_MIN_MATCHES  = 3'd1,
    CFG_SAMPLE_COUNT = 3'd2,
    CFG_FRAME_WIDTH  = 3'd3,
    CFG_FRAME_HEIGHT = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    REQ_SEED     = 1'b0,
    REQ_CLASSIFY = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    DIR_NW = 3'd0,
    DIR_N  = 3'd1,
    DIR_NE = 3'd2,
    DIR_SW = 3'd3,
    DIR_S  = 3'd4,
    DIR_SE = 3'd5,
    DIR_W  = 3'd6,
    DIR_E  = 3'd7
  } nbr_dir_e;

  typedef struct packed {
    logic       req_type;
    logic [1:0] chan;
    logic [8:0] pix_row;
    logic [8:0] pix_col;
    logic [7:0] pixel_value;
    logic [7:0] self_draw;
    logic [4:0] self_slot;
    logic [7:0] nbr_draw;
    logic [2:0] nbr_dir;
    logic [4:0] nbr_slot;
  } vbpc_in_t;

  typedef struct packed {
    logic       foreground;
    logic [1:0] out_chan;
    logic [8:0] out_row;
    logic [8:0] out_col;
  } vbpc_out_t;

  typedef struct packed {
    logic [7:0] match_radius;
    logic [5:0] min_matches;
    logic [5:0] sample_count;
    logic [9:0] frame_width;
    logic [9:0] frame_height;
  } vbpc_cfg_t;

  typedef struct packed {
    logic row_dec;
    logic row_inc;
    logic col_dec;
    logic col_inc;
  } nbr_step_t;

  function automatic nbr_step_t nbr_step(logic [2:0] dir);
    nbr_step_t s;
    s = '0;
    unique case (nbr_dir_e'(dir))
      DIR_NW: begin s.row_dec = 1'b1; s.col_dec = 1'b1; end
      DIR_N:  begin s.row_dec = 1'b1; end
      DIR_NE: begin s.row_dec = 1'b1; s.col_inc = 1'b1; end
      DIR_SW: begin s.row_inc = 1'b1; s.col_dec = 1'b1; end
      DIR_S:  begin s.row_inc = 1'b1; end
      DIR_SE: begin s.row_inc = 1'b1; s.col_inc = 1'b1; end
      DIR_W:  begin s.col_dec = 1'b1; end
      DIR_E:  begin s.col_inc = 1'b1; end
    endcase
    return s;
  endfunction

  function automatic logic [3:0] quant_div(logic [7:0] v);
    logic [15:0] p;
    p = 16'(v) * 16'(QUANT_RECIP);
    return 4'(p >> QUANT_SHIFT);
  endfunction

endpackage

`default_nettype wire

>>> src/vbpc_mem.sv
// Sample store: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module vbpc_mem #(
  parameter int              ADDR_W = 25,
  parameter longint unsigned DEPTH  = 64'd25165824
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [7:0]        wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [7:0]        rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/vbpc_engine.sv
// Item sequencer: seeds, reads and counts matching samples, writes refreshes.
// Depends on vbpc_pkg; drives the ports of vbpc_mem.
`timescale 1ns / 1ps
`default_nettype none

module vbpc_engine import vbpc_pkg::*; #(
  parameter int MAX_SAMPLES  = MAX_SAMPLES_DEF,
  parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT   = MAX_HEIGHT_DEF,
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
  localparam int ROW_W  = $clog2(MAX_HEIGHT),
  localparam int COL_W  = $clog2(MAX_WIDTH),
  localparam int SLOT_W = $clog2(MAX_SAMPLES),
  localparam int ADDR_W = CH_W + ROW_W + COL_W + SLOT_W
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire vbpc_cfg_t         cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire vbpc_in_t          in_data_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output vbpc_out_t              res_data_o,
  output logic                   mem_we_o,
  output logic      [ADDR_W-1:0] mem_waddr_o,
  output logic      [7:0]        mem_wdata_o,
  output logic                   mem_re_o,
  output logic      [ADDR_W-1:0] mem_raddr_o,
  input  wire logic [7:0]        mem_rdata_i
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int CMP_W  = (CNT_W > 6) ? CNT_W : 6;
  localparam int DIM_A  = $clog2(MAX_WIDTH + 1);
  localparam int DIM_B  = $clog2(MAX_HEIGHT + 1);
  localparam int DIM_AB = (DIM_A > DIM_B) ? DIM_A : DIM_B;
  localparam int DIM_W  = (DIM_AB > 10) ? DIM_AB : 10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_READ,
    ST_WAIT,
    ST_SELF,
    ST_NBR,
    ST_DONE
  } state_e;

  state_e           state_q, state_d;
  vbpc_in_t         item_q;
  logic [3:0]       quot_q;
  logic [CNT_W-1:0] k_q, k_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             rd_pend_q;
  logic             fg_q, fg_d;

  logic [CMP_W-1:0]  n, sc;
  logic [DIM_W-1:0]  w_eff, h_eff, row_x, col_x;
  logic              accept, chan_ok, seed_ok, interior, k_last, bg;
  logic [7:0]        q, diff;
  logic              hit;
  nbr_step_t         step;
  logic [ROW_W-1:0]  nbr_row;
  logic [COL_W-1:0]  nbr_col;
  logic [SLOT_W-1:0] wslot;
  logic              self_wr, nbr_wr;

  assign sc = CMP_W'(cfg_i.sample_count);
  assign n  = (sc > CMP_W'(MAX_SAMPLES)) ? CMP_W'(MAX_SAMPLES) : sc;

  assign w_eff = (DIM_W'(cfg_i.frame_width) > DIM_W'(MAX_WIDTH))
               ? DIM_W'(MAX_WIDTH) : DIM_W'(cfg_i.frame_width);
  assign h_eff = (DIM_W'(cfg_i.frame_height) > DIM_W'(MAX_HEIGHT))
               ? DIM_W'(MAX_HEIGHT) : DIM_W'(cfg_i.frame_height);

  assign row_x    = DIM_W'(in_data_i.pix_row);
  assign col_x    = DIM_W'(in_data_i.pix_col);
  assign chan_ok  = {1'b0, in_data_i.chan} < 3'(NUM_CHANNELS);
  assign seed_ok  = chan_ok && (row_x < DIM_W'(MAX_HEIGHT)) && (col_x < DIM_W'(MAX_WIDTH));
  assign interior = (row_x != '0) && (col_x != '0)
                 && ((row_x + DIM_W'(1)) < h_eff) && ((col_x + DIM_W'(1)) < w_eff);

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign k_last     = (CMP_W'(k_q) + CMP_W'(1)) == n;

  assign q    = 8'(12'(quot_q) * 12'(QUANT_STEP));
  assign diff = (mem_rdata_i > q) ? (mem_rdata_i - q) : (q - mem_rdata_i);
  assign hit  = diff <= cfg_i.match_radius;
  assign bg   = CMP_W'(cnt_q) >= CMP_W'(cfg_i.min_matches);

  assign step    = nbr_step(item_q.nbr_dir);
  assign nbr_row = ROW_W'(item_q.pix_row) - ROW_W'(step.row_dec) + ROW_W'(step.row_inc);
  assign nbr_col = COL_W'(item_q.pix_col) - COL_W'(step.col_dec) + COL_W'(step.col_inc);

  assign self_wr = bg && (item_q.self_draw == '0) && (CMP_W'(item_q.self_slot) < n);
  assign nbr_wr  = !fg_q && (item_q.nbr_draw == '0) && (CMP_W'(item_q.nbr_slot) < n);

  always_comb begin
    mem_we_o = 1'b0;
    wslot    = k_q[SLOT_W-1:0];
    unique case (state_q)
      ST_SEED: mem_we_o = 1'b1;
      ST_SELF: begin
        mem_we_o = self_wr;
        wslot    = SLOT_W'(item_q.self_slot);
      end
      ST_NBR: begin
        mem_we_o = nbr_wr;
        wslot    = SLOT_W'(item_q.nbr_slot);
      end
      default: ;
    endcase
  end

  assign mem_waddr_o = (state_q == ST_NBR)
    ? {CH_W'(item_q.chan), nbr_row, nbr_col, wslot}
    : {CH_W'(item_q.chan), ROW_W'(item_q.pix_row), COL_W'(item_q.pix_col), wslot};
  assign mem_wdata_o = (state_q == ST_SEED) ? item_q.pixel_value : q;
  assign mem_re_o    = (state_q == ST_READ);
  assign mem_raddr_o = {CH_W'(item_q.chan), ROW_W'(item_q.pix_row),
                        COL_W'(item_q.pix_col), k_q[SLOT_W-1:0]};

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    fg_d    = fg_q;
    if (rd_pend_q && hit) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          k_d   = '0;
          cnt_d = '0;
          fg_d  = 1'b0;
          if (in_data_i.req_type == REQ_SEED) begin
            state_d = (seed_ok && n != '0) ? ST_SEED : ST_DONE;
          end else if (!chan_ok || !interior) begin
            state_d = ST_DONE;
          end else begin
            state_d = (n != '0) ? ST_READ : ST_SELF;
          end
        end
      end
      ST_SEED: begin
        k_d = k_q + CNT_W'(1);
        if (k_last) begin
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        k_d = k_q + CNT_W'(1);
        if (k_last) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: state_d = ST_SELF;
      ST_SELF: begin
        fg_d    = !bg;
        state_d = ST_NBR;
      end
      ST_NBR:  state_d = ST_DONE;
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      k_q       <= '0;
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
      fg_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      cnt_q     <= cnt_d;
      rd_pend_q <= mem_re_o;
      fg_q      <= fg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
      quot_q <= quant_div(in_data_i.pixel_value);
    end
  end

  assign res_valid_o           = (state_q == ST_DONE);
  assign res_data_o.foreground = fg_q;
  assign res_data_o.out_chan   = item_q.chan;
  assign res_data_o.out_row    = item_q.pix_row;
  assign res_data_o.out_col    = item_q.pix_col;

  a_rw_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_re_o && mem_we_o))
    else $error("read and write of the sample store in one cycle");

  a_no_pend_at_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !rd_pend_q)
    else $error("result offered with a sample read in flight");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second transfer taken while an item is in progress");

  a_slot_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (CMP_W'(wslot) < n))
    else $error("write to a slot beyond the samples in use");

endmodule

`default_nettype wire

>>> src/vibe_background_pixel_classifier_core.sv
// One item at a time: a seed writes its pixel's n stored samples, an interior classify
// reads them and counts matches, and a border or ignored item goes straight to its result;
// n is sample_count capped at MAX_SAMPLES. Classify reads go through the single read
// port of the sample store (one stored sample per cycle). A result may wait in the
// output register while the next item is taken. Reset restores register defaults;
// the sample store is not cleared and holds garbage until a pixel is seeded.
`timescale 1ns / 1ps
`default_nettype none

module vibe_background_pixel_classifier_core import vbpc_pkg::*; #(
  parameter int MAX_SAMPLES  = MAX_SAMPLES_DEF,
  parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT   = MAX_HEIGHT_DEF,
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [2:0] cfg_index_i,
  input  wire logic [9:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire vbpc_in_t   in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output vbpc_out_t       out_data_o
);

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int SLOT_W = $clog2(MAX_SAMPLES);
  localparam int ADDR_W = CH_W + ROW_W + COL_W + SLOT_W;
  localparam longint unsigned DEPTH =
    longint'(NUM_CHANNELS) << (ROW_W + COL_W + SLOT_W);

  vbpc_cfg_t cfg_q;
  logic      out_valid_q;
  vbpc_out_t out_data_q;

  logic              res_valid, res_ready;
  vbpc_out_t         res_data;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_radius <= MATCH_RADIUS_RST;
      cfg_q.min_matches  <= MIN_MATCHES_RST;
      cfg_q.sample_count <= SAMPLE_COUNT_RST;
      cfg_q.frame_width  <= FRAME_WIDTH_RST;
      cfg_q.frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MATCH_RADIUS: cfg_q.match_radius <= cfg_data_i[7:0];
        CFG_MIN_MATCHES:  cfg_q.min_matches  <= cfg_data_i[5:0];
        CFG_SAMPLE_COUNT: cfg_q.sample_count <= cfg_data_i[5:0];
        CFG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data_i;
        CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data_i;
        default: ;
      endcase
    end
  end

  vbpc_engine #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  vbpc_mem #(
    .ADDR_W (ADDR_W),
    .DEPTH  (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for vibe_background_pixel_classifier_core: directed, random and backpressure tests.
// A private copy of the sample store predicts every verdict. Depends on vbpc_pkg.

module tb;
  import vbpc_pkg::*;

  // longest quiet stretch: receiver hold-off plus one full item at 32 samples
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 48;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 160;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  vbpc_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  vbpc_out_t   out_data;

  logic [7:0]  sample_mem [int];
  logic [7:0]  radius_cfg;
  logic [5:0]  min_match_cfg;
  logic [5:0]  nsamp_cfg;
  logic [9:0]  width_cfg;
  logic [9:0]  height_cfg;
  vbpc_out_t   verdict_q [$];
  vbpc_out_t   want_verdict;
  int          err_count = 0;
  int          hold_left = 0;
  int          stall_cycles = 0;
  bit          no_idle = 1'b0;

  vibe_background_pixel_classifier_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #5 clk = ~clk;

  function automatic int eff_samples();
    return (nsamp_cfg > MAX_SAMPLES_DEF) ? MAX_SAMPLES_DEF : int'(nsamp_cfg);
  endfunction

  function automatic int eff_width();
    return (width_cfg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(width_cfg);
  endfunction

  function automatic int eff_height();
    return (height_cfg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(height_cfg);
  endfunction

  function automatic int sample_addr(int ch, int r, int c, int k);
    return ((ch * MAX_HEIGHT_DEF + r) * MAX_WIDTH_DEF + c) * MAX_SAMPLES_DEF + k;
  endfunction

  function automatic bit is_interior(int r, int c);
    return r >= 1 && c >= 1 && r + 1 < eff_height() && c + 1 < eff_width();
  endfunction

  function automatic bit reads_store(vbpc_in_t it);
    return it.req_type == REQ_CLASSIFY && it.chan < NUM_CHANNELS_DEF &&
           is_interior(it.pix_row, it.pix_col);
  endfunction

  function automatic bit slots_written(int ch, int r, int c);
    for (int k = 0; k < eff_samples(); k++)
      if (!sample_mem.exists(sample_addr(ch, r, c, k))) return 1'b0;
    return 1'b1;
  endfunction

  // Verdict for one accepted item; applies seeds and refreshes to the store copy.
  function automatic vbpc_out_t predict_verdict(vbpc_in_t it);
    vbpc_out_t res;
    int n, q, hits, d, r, c, ch, nr, nc;
    n  = eff_samples();
    r  = it.pix_row;
    c  = it.pix_col;
    ch = it.chan;
    res.foreground = 1'b0;
    res.out_chan   = it.chan;
    res.out_row    = it.pix_row;
    res.out_col    = it.pix_col;
    if (it.req_type == REQ_SEED) begin
      if (ch < NUM_CHANNELS_DEF && r < MAX_HEIGHT_DEF && c < MAX_WIDTH_DEF)
        for (int k = 0; k < n; k++) sample_mem[sample_addr(ch, r, c, k)] = it.pixel_value;
    end else if (reads_store(it)) begin
      q = QUANT_STEP * (int'(it.pixel_value) / QUANT_STEP);
      hits = 0;
      for (int k = 0; k < n; k++) begin
        d = int'(sample_mem[sample_addr(ch, r, c, k)]) - q;
        if (d < 0) d = -d;
        if (d <= int'(radius_cfg)) hits++;
      end
      if (hits >= int'(min_match_cfg)) begin
        if (it.self_draw == 8'd0 && int'(it.self_slot) < n)
          sample_mem[sample_addr(ch, r, c, it.self_slot)] = 8'(q);
        if (it.nbr_draw == 8'd0 && int'(it.nbr_slot) < n) begin
          nr = r;
          nc = c;
          case (nbr_dir_e'(it.nbr_dir))
            DIR_NW: begin nr--; nc--; end
            DIR_N:  nr--;
            DIR_NE: begin nr--; nc++; end
            DIR_SW: begin nr++; nc--; end
            DIR_S:  nr++;
            DIR_SE: begin nr++; nc++; end
            DIR_W:  nc--;
            DIR_E:  nc++;
          endcase
          sample_mem[sample_addr(ch, nr, nc, it.nbr_slot)] = 8'(q);
        end
      end else begin
        res.foreground = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic int near_value(int v);
    int x;
    x = v + int'($urandom_range(0, 40)) - 20;
    return (x < 0) ? 0 : (x > 255) ? 255 : x;
  endfunction

  function automatic int pick_coord(int size);
    int p, x, far;
    p = $urandom_range(99);
    far = (size - 2 < 1) ? 1 : size - 2;
    if (p < 55) x = $urandom_range(1, (far < 5) ? far : 5);
    else if (p < 70) x = far - int'($urandom_range(0, 2));
    else if (p < 85) x = ($urandom_range(1) == 0) ? 0 : size - 1;
    else x = $urandom_range(0, 511);
    return (x < 0) ? 0 : (x > 511) ? 511 : x;
  endfunction

  function automatic vbpc_in_t make_item(req_e req, int ch, int r, int c, int v, int sd,
                                         int ss, int nd, nbr_dir_e dir, int ns);
    vbpc_in_t it;
    it.req_type    = req;
    it.chan        = 2'(ch);
    it.pix_row     = 9'(r);
    it.pix_col     = 9'(c);
    it.pixel_value = 8'(v);
    it.self_draw   = 8'(sd);
    it.self_slot   = 5'(ss);
    it.nbr_draw    = 8'(nd);
    it.nbr_dir     = dir;
    it.nbr_slot    = 5'(ns);
    return it;
  endfunction

  function automatic vbpc_in_t random_item();
    vbpc_in_t it;
    int in_use, base;
    in_use = (eff_samples() < 1) ? 1 : eff_samples();
    it.req_type    = ($urandom_range(99) < 12) ? REQ_SEED : REQ_CLASSIFY;
    it.chan        = ($urandom_range(99) < 5) ? 2'd3 : 2'($urandom_range(2));
    it.pix_row     = 9'(pick_coord(eff_height()));
    it.pix_col     = 9'(pick_coord(eff_width()));
    it.pixel_value = 8'($urandom_range(255));
    base = sample_addr(it.chan, it.pix_row, it.pix_col, 0);
    if (it.chan < NUM_CHANNELS_DEF && sample_mem.exists(base) && $urandom_range(99) < 70)
      it.pixel_value = 8'(near_value(sample_mem[base]));
    it.self_draw = ($urandom_range(99) < 35) ? 8'd0 : 8'($urandom_range(255));
    it.self_slot = ($urandom_range(99) < 70) ? 5'($urandom_range(in_use - 1))
                                             : 5'($urandom_range(31));
    it.nbr_draw  = ($urandom_range(99) < 35) ? 8'd0 : 8'($urandom_range(255));
    it.nbr_dir   = 3'($urandom_range(7));
    it.nbr_slot  = ($urandom_range(99) < 70) ? 5'($urandom_range(in_use - 1))
                                             : 5'($urandom_range(31));
    return it;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    err_count++;
    if (err_count <= 100)
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(vbpc_in_t it);
    vbpc_out_t pred;
    if (!no_idle && $urandom_range(99) < 27) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = predict_verdict(it);
    verdict_q = {verdict_q, pred};
    @(negedge clk);
  endtask

  // seeds the pixel first when a classify would read slots never written
  task automatic send_pixel(vbpc_in_t it);
    vbpc_in_t seed;
    if (reads_store(it) && !slots_written(it.chan, it.pix_row, it.pix_col)) begin
      seed = it;
      seed.req_type = REQ_SEED;
      seed.pixel_value = 8'(near_value(it.pixel_value));
      send_item(seed);
    end
    send_item(it);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [9:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MATCH_RADIUS: radius_cfg    = val[7:0];
      CFG_MIN_MATCHES:  min_match_cfg = val[5:0];
      CFG_SAMPLE_COUNT: nsamp_cfg     = val[5:0];
      CFG_FRAME_WIDTH:  width_cfg     = val;
      CFG_FRAME_HEIGHT: height_cfg    = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_config(int radius, int min_m, int nsamp, int fw, int fh);
    drain();
    write_reg(CFG_MATCH_RADIUS, 10'(radius));
    write_reg(CFG_MIN_MATCHES, 10'(min_m));
    write_reg(CFG_SAMPLE_COUNT, 10'(nsamp));
    write_reg(CFG_FRAME_WIDTH, 10'(fw));
    write_reg(CFG_FRAME_HEIGHT, 10'(fh));
  endtask

  task automatic test_directed();
    send_pixel(make_item(REQ_SEED, 0, 5, 5, 100, 255, 31, 255, DIR_E, 31));
    send_pixel(make_item(REQ_CLASSIFY, 0, 5, 5, 119, 255, 0, 255, DIR_NW, 0));
    send_pixel(make_item(REQ_CLASSIFY, 0, 5, 5, 255, 0, 1, 0, DIR_N, 1));
    send_pixel(make_item(REQ_CLASSIFY, 0, 5, 5, 0, 0, 2, 0, DIR_S, 2));
    for (int d = 0; d < 8; d++)
      send_pixel(make_item(REQ_CLASSIFY, 0, 5, 5, 100 + d, (d % 2 == 0) ? 0 : 1, d, 0,
                           nbr_dir_e'(d), d));
    // refresh slots past the ones in use
    send_pixel(make_item(REQ_CLASSIFY, 0, 5, 5, 90, 0, 31, 0, DIR_E, 20));
    send_pixel(make_item(REQ_CLASSIFY, 1, 0, 5, 50, 0, 0, 0, DIR_S, 0));
    send_pixel(make_item(REQ_CLASSIFY, 1, 5, 0, 50, 0, 0, 0, DIR_E, 0));
    send_pixel(make_item(REQ_CLASSIFY, 1, 511, 5, 50, 0, 0, 0, DIR_N, 0));
    send_pixel(make_item(REQ_CLASSIFY, 1, 5, 511, 50, 0, 0, 0, DIR_W, 0));
    send_pixel(make_item(REQ_SEED, 3, 7, 7, 80, 0, 0, 0, DIR_NW, 0));
    send_pixel(make_item(REQ_CLASSIFY, 3, 7, 7, 80, 0, 0, 0, DIR_SE, 0));
    send_pixel(make_item(REQ_SEED, 2, 511, 511, 255, 255, 31, 255, DIR_E, 31));
    send_pixel(make_item(REQ_SEED, 0, 0, 0, 0, 0, 0, 0, DIR_NW, 0));
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: ;
        1: apply_config(255, 1, 1, 3, 3);
        2: apply_config(0, 32, 32, 1023, 1023);
        3: apply_config(40, 0, 63, 600, 16);
        4: apply_config(30, 3, 0, 20, 512);
        5: apply_config(20, 63, 8, 0, 10);
        6: apply_config(60, 4, 12, 64, 64);
        default: apply_config($urandom_range(255), $urandom_range(1, 8),
                              $urandom_range(1, 32), $urandom_range(3, 40),
                              $urandom_range(3, 40));
      endcase
      no_idle = (ph == 6);
      repeat (PHASE_ITEMS) send_pixel(random_item());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    drain();
    hold_left = HOLD_CYCLES;
    repeat (16) send_pixel(random_item());
    drain();
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = no_idle || ($urandom_range(99) >= 27);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("result with none pending, row", out_data.out_row, -1);
      end else begin
        want_verdict = verdict_q.pop_front();
        if (out_data.foreground !== want_verdict.foreground)
          report_mismatch("foreground", out_data.foreground, want_verdict.foreground);
        if (out_data.out_chan !== want_verdict.out_chan)
          report_mismatch("out_chan", out_data.out_chan, want_verdict.out_chan);
        if (out_data.out_row !== want_verdict.out_row)
          report_mismatch("out_row", out_data.out_row, want_verdict.out_row);
        if (out_data.out_col !== want_verdict.out_col)
          report_mismatch("out_col", out_data.out_col, want_verdict.out_col);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    radius_cfg    = MATCH_RADIUS_RST;
    min_match_cfg = MIN_MATCHES_RST;
    nsamp_cfg     = SAMPLE_COUNT_RST;
    width_cfg     = FRAME_WIDTH_RST;
    height_cfg    = FRAME_HEIGHT_RST;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_traffic();
    test_backpressure();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (verdict_q.size() != 0) report_mismatch("verdicts left pending", verdict_q.size(), 0);
    if (err_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
